/* hdl/lar_pkg.sv */
// ----------------------------------------------------------------------------
// lar_pkg
// Shared types and constants for the true-LRU age-counter replacement block:
// transfer payloads, opcode and status codes, controller states.
// ----------------------------------------------------------------------------
package lar_pkg;

    // Default geometry
    localparam int unsigned NUM_SETS_DEF = 64;
    localparam int unsigned WAYS_DEF     = 8;

    // Fixed field widths of the transfer payloads
    localparam int unsigned SET_IDX_W   = 6;
    localparam int unsigned WAY_FIELD_W = 3;
    localparam int unsigned MASK_W      = 8;

    typedef enum logic {
        OP_QUERY = 1'b0,
        OP_TOUCH = 1'b1
    } t_opcode;

    typedef enum logic {
        STATUS_OK        = 1'b0,
        STATUS_NO_OLDEST = 1'b1
    } t_status;

    typedef struct packed {
        t_opcode                opcode;
        logic [SET_IDX_W-1:0]   set_index;
        logic [WAY_FIELD_W-1:0] access_way;
        logic [MASK_W-1:0]      valid_mask;
    } t_in_item;

    typedef struct packed {
        logic [WAY_FIELD_W-1:0] victim_way;
        logic                   from_invalid;
        t_status                status;
    } t_out_item;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_ctrl_state;

endpackage

/* hdl/lar_ram.sv */
// ----------------------------------------------------------------------------
// lar_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module lar_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, held when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/lar_age_logic.sv */
// ----------------------------------------------------------------------------
// lar_age_logic
// Modify step of the age read-modify-write: picks the victim way of a query
// and computes the aged row of a touch.
// ----------------------------------------------------------------------------
module lar_age_logic #(
    parameter int unsigned WAYS = lar_pkg::WAYS_DEF,
    localparam int unsigned AGE_W = $clog2(WAYS),
    localparam int unsigned ROW_W = WAYS * AGE_W
) (
    input  lar_pkg::t_in_item  i_item,
    input  logic [ROW_W-1:0]   i_row,
    output lar_pkg::t_out_item o_result,
    output logic               o_wr_en,
    output logic [ROW_W-1:0]   o_new_row
);

    localparam logic [AGE_W-1:0] OLDEST = AGE_W'(WAYS - 1);

    logic [AGE_W-1:0] ages [WAYS];
    logic [WAYS-1:0]  way_valid;
    logic             inv_found;
    logic [lar_pkg::WAY_FIELD_W-1:0] inv_way;
    logic             old_found;
    logic [lar_pkg::WAY_FIELD_W-1:0] old_way;
    logic             touch_ok;
    logic [AGE_W-1:0] ref_age;

    // Split the row; ways beyond the mask field count as invalid
    for (genvar w = 0; w < WAYS; w++) begin : g_way
        assign ages[w] = i_row[w*AGE_W +: AGE_W];
        if (w < lar_pkg::MASK_W) begin : g_in_mask
            assign way_valid[w] = i_item.valid_mask[w];
        end else begin : g_beyond_mask
            assign way_valid[w] = 1'b0;
        end
    end

    // Lowest invalid way and highest way carrying the oldest age
    always_comb begin
        inv_found = 1'b0;
        inv_way   = '0;
        old_found = 1'b0;
        old_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (!way_valid[w]) begin
                inv_found = 1'b1;
                inv_way   = lar_pkg::WAY_FIELD_W'(w);
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            if (ages[w] == OLDEST) begin
                old_found = 1'b1;
                old_way   = lar_pkg::WAY_FIELD_W'(w);
            end
        end
    end

    // Age of the touched way; a way number beyond the set leaves the row alone
    always_comb begin
        touch_ok = 1'b0;
        ref_age  = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (int'(i_item.access_way) == w) begin
                touch_ok = 1'b1;
                ref_age  = ages[w];
            end
        end
    end

    // Advance every younger way, make the touched way the youngest
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            if (int'(i_item.access_way) == w) begin
                o_new_row[w*AGE_W +: AGE_W] = '0;
            end else if (ages[w] < ref_age) begin
                o_new_row[w*AGE_W +: AGE_W] = ages[w] + AGE_W'(1);
            end else begin
                o_new_row[w*AGE_W +: AGE_W] = ages[w];
            end
        end
    end

    assign o_wr_en = (i_item.opcode == lar_pkg::OP_TOUCH) && touch_ok;

    // Result: touches report all zero
    always_comb begin
        o_result.victim_way   = '0;
        o_result.from_invalid = 1'b0;
        o_result.status       = lar_pkg::STATUS_OK;
        if (i_item.opcode == lar_pkg::OP_QUERY) begin
            if (inv_found) begin
                o_result.victim_way   = inv_way;
                o_result.from_invalid = 1'b1;
            end else if (old_found) begin
                o_result.victim_way = old_way;
            end else begin
                o_result.status = lar_pkg::STATUS_NO_OLDEST;
            end
        end
    end

endmodule

/* hdl/lru_age_replacement_top.sv */
// Results are registered as stage 1 advances. Throughput: one operation per cycle
// unless the output stalls; the age RAM is read at transfer, modified and written back
// when stage 1 advances, with the row written at the read edge bypassed in. Reset:
// synchronous, active low; afterwards a clearing pass writes the initial ages to every
// set, with input ready held low until it completes.
// ----------------------------------------------------------------------------
// lru_age_replacement_top
// True-LRU age-counter replacement state for a set-associative cache: victim
// queries and touches over per-set age rows kept in one synchronous RAM.
// ----------------------------------------------------------------------------
module lru_age_replacement_top #(
    parameter int unsigned NUM_SETS = lar_pkg::NUM_SETS_DEF,
    parameter int unsigned WAYS     = lar_pkg::WAYS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lar_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lar_pkg::t_out_item o_out_data
);

    localparam int unsigned SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int unsigned AGE_W     = $clog2(WAYS);
    localparam int unsigned ROW_W     = WAYS * AGE_W;
    localparam int unsigned IDX_RANGE = 1 << lar_pkg::SET_IDX_W;

    lar_pkg::t_ctrl_state r_state;
    lar_pkg::t_ctrl_state n_state;
    logic [SET_W-1:0]     r_clr_idx;
    logic                 clr_last;
    logic                 clr_active;
    logic                 run_mode;

    logic [SET_W-1:0]     set_map [IDX_RANGE];
    logic [ROW_W-1:0]     init_row;
    logic [SET_W-1:0]     in_set;
    logic                 in_fire;

    logic                 r_s1_valid;
    lar_pkg::t_in_item    r_s1_item;
    logic [SET_W-1:0]     r_s1_set;
    logic                 r_fwd_hit;
    logic [ROW_W-1:0]     r_fwd_row;
    logic                 s1_adv;

    logic [ROW_W-1:0]     rd_row;
    logic [ROW_W-1:0]     cur_row;
    logic [ROW_W-1:0]     upd_row;
    logic                 upd_wr;
    lar_pkg::t_out_item   upd_res;
    logic                 wb_en;

    logic                 ram_wr_en;
    logic [SET_W-1:0]     ram_wr_addr;
    logic [ROW_W-1:0]     ram_wr_data;

    logic                 r_out_valid;
    lar_pkg::t_out_item   r_out_data;

    // Fold the set field onto the configured number of sets
    for (genvar i = 0; i < IDX_RANGE; i++) begin : g_set_map
        localparam int unsigned MAPPED = i % NUM_SETS;
        assign set_map[i] = SET_W'(MAPPED);
    end

    // Initial row: way k has age k
    for (genvar w = 0; w < WAYS; w++) begin : g_init_row
        assign init_row[w*AGE_W +: AGE_W] = AGE_W'(w);
    end

    // Controller next state
    assign clr_last = (r_clr_idx == SET_W'(NUM_SETS - 1));

    always_comb begin
        case (r_state)
            lar_pkg::ST_CLEAR: begin
                n_state = clr_last ? lar_pkg::ST_RUN : lar_pkg::ST_CLEAR;
            end
            lar_pkg::ST_RUN: begin
                n_state = lar_pkg::ST_RUN;
            end
            default: begin
                n_state = lar_pkg::ST_CLEAR;
            end
        endcase
    end

    // Controller outputs
    always_comb begin
        case (r_state)
            lar_pkg::ST_CLEAR: begin
                clr_active = 1'b1;
                run_mode   = 1'b0;
            end
            lar_pkg::ST_RUN: begin
                clr_active = 1'b0;
                run_mode   = 1'b1;
            end
            default: begin
                clr_active = 1'b0;
                run_mode   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lar_pkg::ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (clr_active) begin
                r_clr_idx <= r_clr_idx + SET_W'(1);
            end
        end
    end

    // Handshake: stage 1 drains into the output register, input follows
    assign in_set     = set_map[i_in_data.set_index];
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = run_mode && (!r_s1_valid || s1_adv);
    assign in_fire    = i_in_valid && o_in_ready;

    // Age RAM: clearing pass or write-back of a touch
    assign wb_en       = s1_adv && upd_wr;
    assign ram_wr_en   = clr_active || wb_en;
    assign ram_wr_addr = clr_active ? r_clr_idx : r_s1_set;
    assign ram_wr_data = clr_active ? init_row : upd_row;

    lar_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_age_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (in_fire),
        .i_rd_addr (in_set),
        .o_rd_data (rd_row)
    );

    // Bypass the row written at the same edge as the read
    assign cur_row = r_fwd_hit ? r_fwd_row : rd_row;

    lar_age_logic #(
        .WAYS (WAYS)
    ) u_age_logic (
        .i_item    (r_s1_item),
        .i_row     (cur_row),
        .o_result  (upd_res),
        .o_wr_en   (upd_wr),
        .o_new_row (upd_row)
    );

    // Stage 1 occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage 1 payload and bypass capture
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item <= i_in_data;
            r_s1_set  <= in_set;
            r_fwd_hit <= wb_en && (r_s1_set == in_set);
            r_fwd_row <= upd_row;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= upd_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* hdl/lar_checker.sv */
// ----------------------------------------------------------------------------
// lar_checker
// Port-level checks for lru_age_replacement_top, attached by bind.
// ----------------------------------------------------------------------------
module lar_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input lar_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input lar_pkg::t_out_item o_out_data
);

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    // Refuse transfers straight after reset, while the ages are being cleared
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_in_ready)
        else $error("input ready during clearing pass");

    // Every input transfer is followed by a valid result
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> ##1 o_out_valid)
        else $error("no result after input transfer");

    // Missing oldest way reports way zero, not invalid
    a_no_oldest_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == lar_pkg::STATUS_NO_OLDEST)
        |-> (o_out_data.victim_way == '0) && !o_out_data.from_invalid)
        else $error("inconsistent result fields on missing oldest way");

endmodule

bind lru_age_replacement_top lar_checker u_lar_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
